>>> rtl/reorder_buffer_cumulative_ack_unit_defines.svh
// ----------------------------------------------------------------------------
// Reorder buffer assertion macros
// Shorthand for the concurrent checks written at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef REORDER_BUFFER_CUMULATIVE_ACK_UNIT_DEFINES_SVH
`define REORDER_BUFFER_CUMULATIVE_ACK_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while arst_n is low.
`define ROCA_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet while arst_n is low.
`define ROCA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/roca_pkg.sv
// ----------------------------------------------------------------------------
// Reorder buffer package
// Shared types, result codes and default sizes of the reorder buffer.
// ----------------------------------------------------------------------------
package roca_pkg;

	// Default window depth in slots and default slot span in bytes.
	localparam int WINDOW_SLOTS_DEF  = 32;
	localparam int SEGMENT_BYTES_DEF = 1024;

	// Result kinds.
	localparam logic [1:0] KIND_DELIVER = 2'd0;
	localparam logic [1:0] KIND_ACK     = 2'd1;
	localparam logic [1:0] KIND_END     = 2'd2;

	// One segment descriptor as it arrives.
	typedef struct packed {
		logic [31:0] seq_number;
		logic [10:0] payload_size;
		logic [7:0]  payload_tag;
	} seg_t;

	// One result as it leaves.
	typedef struct packed {
		logic [1:0]  result_kind;
		logic [31:0] number;
		logic [10:0] delivered_size;
		logic [7:0]  delivered_tag;
		logic        dropped_beyond_window;
		logic        last_result;
	} res_t;

	// Contents of one window slot.
	typedef struct packed {
		logic valid;
		seg_t desc;
	} cell_t;

	// Control broadcast from the sequencer to every slot.
	typedef struct packed {
		logic        shift;
		logic        store;
		logic [31:0] offset;
		seg_t        item;
	} cell_ctrl_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DRAIN
	} state_t;

endpackage

>>> rtl/reorder_buffer_cumulative_ack_unit.sv
// ----------------------------------------------------------------------------
// Reorder buffer with cumulative acknowledgement
// Receive side of a selective-repeat link: segments are stored by offset from
// the expected sequence number, delivered in order and answered by an ack.
// ----------------------------------------------------------------------------
// One segment descriptor is taken per transfer on the seg channel while the
// block is idle. A stale segment, a segment stored ahead, a segment dropped
// beyond the window or an end-of-stream marker is taken in the idle state and
// classified in the evaluate state, which presents its single result. An
// in-order segment releases n deliveries in total, then the ack: the window
// is a chain of slots that shifts down by one slot per cycle and slot 0 feeds
// one delivery per cycle to the output register, while that register can take
// a result. A stall on the res channel holds the sequencer for as long as the
// output register is full. Reset clears the slots at once; no sweep is needed.
// ----------------------------------------------------------------------------
`include "reorder_buffer_cumulative_ack_unit_defines.svh"

module reorder_buffer_cumulative_ack_unit #(
	parameter int WINDOW_SLOTS  = roca_pkg::WINDOW_SLOTS_DEF,
	parameter int SEGMENT_BYTES = roca_pkg::SEGMENT_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           seg_valid,
	output logic           seg_stall,
	input  roca_pkg::seg_t seg,
	output logic           res_valid,
	input  logic           res_stall,
	output roca_pkg::res_t res
);
	import roca_pkg::*;

	// Byte span of the whole window.
	localparam logic [32:0] WIN_SPAN = 33'(WINDOW_SLOTS * SEGMENT_BYTES);

	state_t      state_q, state_d;
	seg_t        item_q;
	logic [31:0] exp_q, exp_d;
	logic        exp_load;
	logic        res_valid_q;
	res_t        res_q, res_d;
	logic        emit;
	logic        can_emit;
	logic [32:0] diff;
	logic        in_order;
	logic        ahead;
	logic        beyond;
	cell_ctrl_t  ctrl;
	cell_t       cells [WINDOW_SLOTS + 1];

	// Offset of the held segment from the expected number, with borrow.
	assign diff     = {1'b0, item_q.seq_number} - {1'b0, exp_q};
	assign in_order = (diff == 33'd0);
	assign ahead    = !diff[32] && !in_order;
	assign beyond   = ahead && ({1'b0, diff[31:0]} >= WIN_SPAN);
	assign can_emit = !res_valid_q || !res_stall;

	// Input side takes a transfer only while idle.
	assign seg_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk) begin
		if (seg_valid && !seg_stall) begin
			item_q <= seg;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (seg_valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (can_emit) begin
					if (item_q.payload_size != 11'd0 && in_order) begin
						state_d = ST_DRAIN;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_DRAIN: begin
				if (can_emit && !cells[0].valid) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: result, window control and expected number.
	always_comb begin
		emit        = 1'b0;
		res_d       = '0;
		exp_load    = 1'b0;
		exp_d       = exp_q;
		ctrl.shift  = 1'b0;
		ctrl.store  = 1'b0;
		ctrl.offset = diff[31:0];
		ctrl.item   = item_q;
		case (state_q)
			ST_EVAL: begin
				if (can_emit) begin
					emit = 1'b1;
					if (item_q.payload_size == 11'd0) begin
						res_d.result_kind = KIND_END;
						res_d.last_result = 1'b1;
					end else if (in_order) begin
						// The new segment fills slot 0 and leaves at once.
						res_d.result_kind    = KIND_DELIVER;
						res_d.number         = item_q.seq_number;
						res_d.delivered_size = item_q.payload_size;
						res_d.delivered_tag  = item_q.payload_tag;
						exp_load   = 1'b1;
						exp_d      = item_q.seq_number + 32'(item_q.payload_size);
						ctrl.shift = 1'b1;
					end else begin
						res_d.result_kind           = KIND_ACK;
						res_d.number                = exp_q;
						res_d.dropped_beyond_window = beyond;
						res_d.last_result           = 1'b1;
						ctrl.store = ahead && !beyond;
					end
				end
			end
			ST_DRAIN: begin
				if (can_emit) begin
					emit = 1'b1;
					if (cells[0].valid) begin
						res_d.result_kind    = KIND_DELIVER;
						res_d.number         = cells[0].desc.seq_number;
						res_d.delivered_size = cells[0].desc.payload_size;
						res_d.delivered_tag  = cells[0].desc.payload_tag;
						exp_load   = 1'b1;
						exp_d      = cells[0].desc.seq_number
							+ 32'(cells[0].desc.payload_size);
						ctrl.shift = 1'b1;
					end else begin
						res_d.result_kind = KIND_ACK;
						res_d.number      = exp_q;
						res_d.last_result = 1'b1;
					end
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			exp_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exp_load) begin
				exp_q <= exp_d;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Window: a chain of slots, the top one fed with an empty slot.
	assign cells[WINDOW_SLOTS] = '0;

	for (genvar k = 0; k < WINDOW_SLOTS; k++) begin : g_slot
		roca_cell #(
			.INDEX         (k),
			.SEGMENT_BYTES (SEGMENT_BYTES)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.upper  (cells[k + 1]),
			.cur    (cells[k])
		);
	end

	// Checks.
	`ROCA_ASSERT_NEXT(a_take_eval, seg_valid && !seg_stall, state_q == ST_EVAL, "transfer taken but no evaluation follows")
	`ROCA_ASSERT_NEXT(a_drain_end, state_q == ST_DRAIN && can_emit && !cells[0].valid, state_q == ST_IDLE, "drain did not end after the ack")
	`ROCA_ASSERT_IMPL(a_deliver_not_last, res_valid && res.result_kind == KIND_DELIVER, !res.last_result && !res.dropped_beyond_window, "delivery marked as last or dropped")

endmodule

>>> rtl/roca_cell.sv
// ----------------------------------------------------------------------------
// Reorder buffer window slot
// One slot of the window. It decodes its own byte range for stores and takes
// the contents of its upper neighbor when the window shifts down.
// ----------------------------------------------------------------------------
module roca_cell #(
	parameter int INDEX         = 0,
	parameter int SEGMENT_BYTES = roca_pkg::SEGMENT_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  roca_pkg::cell_ctrl_t ctrl,
	input  roca_pkg::cell_t      upper,
	output roca_pkg::cell_t      cur
);
	import roca_pkg::*;

	// Byte offsets from the expected number that map to this slot.
	localparam logic [32:0] LO_BOUND = 33'(INDEX * SEGMENT_BYTES);
	localparam logic [32:0] HI_BOUND = 33'((INDEX + 1) * SEGMENT_BYTES);

	logic valid_q;
	seg_t desc_q;
	logic hit;

	// Range decode of the store offset.
	assign hit = ({1'b0, ctrl.offset} >= LO_BOUND) && ({1'b0, ctrl.offset} < HI_BOUND);

	// Valid flag: cleared by reset, shifted or set by a store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= upper.valid;
		end else if (ctrl.store && hit) begin
			valid_q <= 1'b1;
		end
	end

	// Descriptor: follows the valid flag, no reset needed.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			desc_q <= upper.desc;
		end else if (ctrl.store && hit) begin
			desc_q <= ctrl.item;
		end
	end

	assign cur.valid = valid_q;
	assign cur.desc  = desc_q;

endmodule

>>> dv/reorder_delivery_checker.sv
// ----------------------------------------------------------------------------
// Reorder buffer delivery checker
// Watches both channels of the reorder buffer, keeps its own copy of the
// expected sequence number and the slot window, and compares every result
// transfer field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module reorder_delivery_checker #(
	parameter int WIN  = roca_pkg::WINDOW_SLOTS_DEF,
	parameter int SPAN = roca_pkg::SEGMENT_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           seg_valid,
	input  logic           seg_stall,
	input  roca_pkg::seg_t seg,
	input  logic           res_valid,
	input  logic           res_stall,
	input  roca_pkg::res_t res,
	output logic [31:0]    ack_point,
	output int             pending,
	output int             mismatches,
	output int             deliveries,
	output int             acks,
	output int             drops,
	output int             ends,
	output int             longest_drain
);
	import roca_pkg::*;

	// Shadow of the block state: next in-order byte offset and the slot window.
	logic [31:0] next_seq;
	logic        slot_full [WIN];
	seg_t        slot_seg [WIN];

	// Results predicted but not yet seen on the res channel, oldest first.
	res_t        due_results [$];
	int          checked;

	// Print one line per mismatch and count it.
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: result %0d, %s: got 0x%0h, expected 0x%0h",
			$time, checked, what, got, want);
		mismatches++;
	endtask

	// Work out every result that one accepted segment causes.
	task automatic reorder_segment(input seg_t s);
		res_t        r;
		int          released;
		logic        dropped;
		logic [31:0] slot_idx;
		released = 0;
		dropped  = 1'b0;

		// A zero size marks the end of the stream and leaves the state alone.
		if (s.payload_size == '0) begin
			r = '0;
			r.result_kind = KIND_END;
			r.last_result = 1'b1;
			due_results.push_back(r);
			return;
		end

		if (s.seq_number == next_seq) begin
			// In order: fill slot 0, then release filled slots up to the first gap.
			slot_seg[0]  = s;
			slot_full[0] = 1'b1;
			while (released < WIN && slot_full[released]) begin
				r = '0;
				r.result_kind    = KIND_DELIVER;
				r.number         = slot_seg[released].seq_number;
				r.delivered_size = slot_seg[released].payload_size;
				r.delivered_tag  = slot_seg[released].payload_tag;
				due_results.push_back(r);
				next_seq = slot_seg[released].seq_number +
					32'(slot_seg[released].payload_size);
				released++;
			end
			if (released > longest_drain)
				longest_drain = released;

			// Shift the window down by the number of slots released.
			for (int k = 0; k < WIN; k++) begin
				if (k + released < WIN) begin
					slot_full[k] = slot_full[k + released];
					slot_seg[k]  = slot_seg[k + released];
				end else begin
					slot_full[k] = 1'b0;
				end
			end
		end else if (s.seq_number > next_seq) begin
			// Ahead: store in its slot, or drop it when it lies past the window.
			slot_idx = (s.seq_number - next_seq) / 32'(SPAN);
			if (slot_idx < 32'(WIN)) begin
				slot_seg[slot_idx]  = s;
				slot_full[slot_idx] = 1'b1;
			end else begin
				dropped = 1'b1;
			end
		end

		// Every segment but an end marker, stale ones too, ends with a cumulative ack.
		r = '0;
		r.result_kind           = KIND_ACK;
		r.number                = next_seq;
		r.dropped_beyond_window = dropped;
		r.last_result           = 1'b1;
		due_results.push_back(r);
	endtask

	// Compare one result transfer with the oldest prediction.
	task automatic match_result(input res_t got);
		res_t want;
		checked++;
		if (due_results.size() == 0) begin
			report_mismatch("result with nothing outstanding", 32'(got.result_kind), '0);
			return;
		end
		want = due_results.pop_front();
		if (got.result_kind !== want.result_kind)
			report_mismatch("result_kind", 32'(got.result_kind), 32'(want.result_kind));
		if (got.number !== want.number)
			report_mismatch("number", got.number, want.number);
		if (got.delivered_size !== want.delivered_size)
			report_mismatch("delivered_size", 32'(got.delivered_size),
				32'(want.delivered_size));
		if (got.delivered_tag !== want.delivered_tag)
			report_mismatch("delivered_tag", 32'(got.delivered_tag),
				32'(want.delivered_tag));
		if (got.dropped_beyond_window !== want.dropped_beyond_window)
			report_mismatch("dropped_beyond_window", 32'(got.dropped_beyond_window),
				32'(want.dropped_beyond_window));
		if (got.last_result !== want.last_result)
			report_mismatch("last_result", 32'(got.last_result), 32'(want.last_result));

		// Tally what the run went through.
		case (want.result_kind)
			KIND_DELIVER: deliveries++;
			KIND_ACK:     acks++;
			default:      ends++;
		endcase
		if (want.dropped_beyond_window)
			drops++;
	endtask

	// Sample both channels at the clock edge. Results are checked before the
	// new segment is predicted, since a segment's results come later.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_seq = '0;
			for (int k = 0; k < WIN; k++) begin
				slot_full[k] = 1'b0;
				slot_seg[k]  = '0;
			end
			due_results.delete();
			checked       = 0;
			mismatches    = 0;
			deliveries    = 0;
			acks          = 0;
			drops         = 0;
			ends          = 0;
			longest_drain = 0;
			ack_point <= '0;
			pending   <= 0;
		end else begin
			if (res_valid && !res_stall)
				match_result(res);
			if (seg_valid && !seg_stall)
				reorder_segment(seg);
			ack_point <= next_seq;
			pending   <= due_results.size();
		end
	end

endmodule

>>> dv/reorder_buffer_cumulative_ack_unit_tb.sv
// ----------------------------------------------------------------------------
// Reorder buffer testbench
// Drives segment descriptors into the reorder buffer: a short directed set for
// the corner cases, then window fills in shuffled order, broken fills and
// noise, with random gaps and result stalls. A checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module reorder_buffer_cumulative_ack_unit_tb;
	import roca_pkg::*;

	localparam int WIN          = WINDOW_SLOTS_DEF;
	localparam int SPAN         = SEGMENT_BYTES_DEF;
	localparam int RANDOM_ITEMS = 360;
	localparam int QUIET_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 4 * WIN;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        seg_valid = 1'b0;
	logic        seg_stall;
	seg_t        seg       = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	res_t        res;

	logic [31:0] ack_point;
	int          pending;
	int          mismatches;
	int          deliveries;
	int          acks;
	int          drops;
	int          ends;
	int          longest_drain;

	int          gap_pct       = 0;
	int          stall_pct     = 0;
	int          stall_left    = 0;
	int          quiet_cycles  = 0;
	int          segments_sent = 0;
	int          stale_sent    = 0;
	logic [31:0] stream_pos    = '0;

	always #4 clk = ~clk;

	reorder_buffer_cumulative_ack_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_valid),
		.seg_stall (seg_stall),
		.seg       (seg),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	reorder_delivery_checker #(
		.WIN  (WIN),
		.SPAN (SPAN)
	) order_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.seg_valid     (seg_valid),
		.seg_stall     (seg_stall),
		.seg           (seg),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.res           (res),
		.ack_point     (ack_point),
		.pending       (pending),
		.mismatches    (mismatches),
		.deliveries    (deliveries),
		.acks          (acks),
		.drops         (drops),
		.ends          (ends),
		.longest_drain (longest_drain)
	);

	// Result stalls come in bursts at a rate set per phase.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
			res_stall  <= 1'b1;
			stall_left <= $urandom_range(14, 0);
		end else begin
			res_stall <= 1'b0;
		end
	end

	// End the run when neither channel has moved a transfer for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((seg_valid && !seg_stall) || (res_valid && !res_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QUIET_LIMIT) begin
				$display("Watchdog: no transfer on either channel for %0d cycles.",
					QUIET_LIMIT);
				$display("== FAIL ==");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Present one descriptor, hold it until the transfer, then maybe pause.
	task automatic send_segment(input logic [31:0] seqno, input logic [10:0] size,
			input logic [7:0] tag);
		seg_t item;
		item.seq_number   = seqno;
		item.payload_size = size;
		item.payload_tag  = tag;
		seg       <= item;
		seg_valid <= 1'b1;
		@(posedge clk);
		while (seg_stall)
			@(posedge clk);
		segments_sent++;
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			seg_valid <= 1'b0;
			repeat ($urandom_range(15, 1)) @(posedge clk);
		end
	endtask

	// Drop valid for one cycle so the checker's ack point covers every
	// segment sent so far, then take it as the start of the next fill.
	task automatic sync_stream_pos();
		seg_valid <= 1'b0;
		@(posedge clk);
		stream_pos = ack_point;
	endtask

	// Mostly full-span segments, now and then any nonzero size the field allows.
	function automatic logic [10:0] pick_size();
		if ($urandom_range(99) < 80)
			return 11'(SPAN);
		return 11'($urandom_range(2047, 1));
	endfunction

	function automatic int pick_pct();
		case ($urandom_range(2, 0))
			0:       return 0;
			1:       return 12;
			default: return 40;
		endcase
	endfunction

	// Single descriptors that do not follow the stream.
	task automatic send_noise();
		logic [31:0] far;
		case ($urandom_range(4, 0))
			0: send_segment($urandom, 11'd0, 8'($urandom));
			1: begin
				if (stream_pos == 0) begin
					send_segment($urandom, 11'd0, 8'($urandom));
				end else begin
					stale_sent++;
					send_segment($urandom_range(stream_pos - 1, 0), pick_size(),
						8'($urandom));
				end
			end
			2: begin
				// Just past the window, or far out in the upper half of the space.
				if ($urandom_range(1, 0) == 1)
					far = stream_pos + 32'(WIN * SPAN) + $urandom_range(SPAN - 1, 0);
				else
					far = $urandom | 32'h8000_0000;
				send_segment(far, pick_size(), 8'($urandom));
			end
			3: send_segment($urandom, 11'($urandom_range(2047, 0)), 8'($urandom));
			default: send_segment(stream_pos, 11'($urandom_range(2047, SPAN + 1)),
				8'($urandom));
		endcase
	endtask

	// Fill slots 1 to count-1 in shuffled order, then close the gap at slot 0.
	// A broken fill leaves one slot out, slot 0 included.
	task automatic run_window_fill(input int count, input bit complete);
		int          order [$];
		int          hole;
		int          pick;
		int          swap;
		logic [31:0] base;
		sync_stream_pos();
		base = stream_pos;
		if (complete)
			hole = -1;
		else
			hole = int'($urandom_range(count - 1, 0));
		for (int k = 1; k < count; k++)
			order.push_back(k);
		for (int k = order.size() - 1; k > 0; k--) begin
			pick        = int'($urandom_range(k, 0));
			swap        = order[k];
			order[k]    = order[pick];
			order[pick] = swap;
		end

		foreach (order[i]) begin
			if (order[i] != hole) begin
				send_segment(base + 32'(order[i] * SPAN), pick_size(), 8'($urandom));
				// Sometimes resend into the occupied slot with another tag.
				if ($urandom_range(99) < 15)
					send_segment(base + 32'(order[i] * SPAN), pick_size(),
						8'($urandom));
			end
			if ($urandom_range(99) < 8)
				send_noise();
		end

		// A segment less than one span ahead lands in slot 0 until the in-order one comes.
		if ($urandom_range(99) < 10)
			send_segment(base + $urandom_range(SPAN - 1, 1), pick_size(), 8'($urandom));
		if (hole != 0)
			send_segment(base, pick_size(), 8'($urandom));
	endtask

	initial begin
		int directed_sent;
		int random_sent;
		int choice;
		int failures;
		bit calm;
		calm = 1'b0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		gap_pct   = 20;
		stall_pct = 20;

		// Directed: end marker straight after reset, with every other field high.
		send_segment(32'hFFFF_FFFF, 11'd0, 8'hFF);
		// First in-order segment, then a stale one behind it.
		send_segment(32'd0, 11'(SPAN), 8'h00);
		send_segment(32'd0, 11'd1, 8'hFF);
		// Ahead by less than one span: it sits in slot 0.
		send_segment(32'(2 * SPAN - 1), 11'd7, 8'hA5);
		// Slot 1, then the same slot again with a new tag.
		send_segment(32'(2 * SPAN), 11'(SPAN), 8'h11);
		send_segment(32'(2 * SPAN), 11'(SPAN), 8'h22);
		// Last slot of the window, the first offset past it, and the far end.
		send_segment(32'(SPAN + (WIN - 1) * SPAN), 11'(SPAN), 8'h33);
		send_segment(32'(SPAN + WIN * SPAN), 11'(SPAN), 8'h44);
		send_segment(32'hFFFF_FFFF, 11'h7FF, 8'h55);
		// In order again: overwrites slot 0 and releases slots 0 and 1.
		send_segment(32'(SPAN), 11'(SPAN), 8'h66);
		// End marker mid-stream must leave the state alone.
		send_segment(32'(3 * SPAN), 11'd0, 8'h00);
		// Oversize payload in order, then the smallest payload.
		send_segment(32'(3 * SPAN), 11'h7FF, 8'h77);
		send_segment(32'(3 * SPAN + 2047), 11'd1, 8'h88);
		// Stale by two spans and by a single byte.
		send_segment(32'(3 * SPAN), 11'(SPAN), 8'h99);
		send_segment(32'(5 * SPAN - 1), 11'd3, 8'h5A);
		// End marker with every field low.
		send_segment(32'd0, 11'd0, 8'h00);
		directed_sent = segments_sent;

		// Random part: mostly well-formed fills, some broken ones, some noise.
		// The last fifth runs without gaps or stalls.
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			if (!calm && random_sent >= RANDOM_ITEMS * 4 / 5) begin
				calm      = 1'b1;
				gap_pct   = 0;
				stall_pct = 0;
			end else if (!calm) begin
				gap_pct   = pick_pct();
				stall_pct = pick_pct();
			end
			choice = int'($urandom_range(99, 0));
			if (choice < 6)
				run_window_fill(WIN, 1'b1);
			else if (choice < 60)
				run_window_fill(int'($urandom_range(8, 1)), 1'b1);
			else if (choice < 75)
				run_window_fill(int'($urandom_range(8, 2)), 1'b0);
			else
				send_noise();
			random_sent = segments_sent - directed_sent;
		end

		// Wait for every predicted result, then watch for strays.
		seg_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		failures = mismatches + pending;
		$display("Sent %0d segment descriptors (%0d stale); longest in-order release %0d slots.",
			segments_sent, stale_sent, longest_drain);
		$display("Checked %0d deliveries, %0d acks (%0d with a window drop), %0d end markers.",
			deliveries, acks, drops, ends);
		if (failures == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
